>>> hw/rtl/bdq_pkg.sv
`default_nettype none
package bdq_pkg;

	localparam int DEPTH_DEF      = 64;
	localparam int DATA_WIDTH_DEF = 32;

	localparam int CMD_W  = 3;
	localparam int WORD_W = 32;
	localparam int POS_W  = 6;
	localparam int STAT_W = 2;
	localparam int LEN_W  = 7;

	typedef enum logic [CMD_W-1:0] {
		CMD_PUSH_FRONT = 3'd0,
		CMD_PUSH_BACK  = 3'd1,
		CMD_POP_FRONT  = 3'd2,
		CMD_POP_BACK   = 3'd3,
		CMD_READ       = 3'd4
	} cmd_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2,
		ST_RANGE = 2'd3
	} status_t;

	typedef struct packed {
		cmd_t              command;
		logic [WORD_W-1:0] value;
		logic [POS_W-1:0]  position;
	} cmd_beat_t;

	typedef struct packed {
		status_t           status;
		logic [WORD_W-1:0] read_word;
		logic [LEN_W-1:0]  length;
	} rsp_beat_t;

	// per-command outcome handed from the pointer logic to the result stage
	typedef struct packed {
		status_t          status;
		logic             rd_ok;
		logic [LEN_W-1:0] length;
	} res_t;

endpackage
`default_nettype wire

>>> hw/rtl/bdq_ram.sv
`default_nettype none
module bdq_ram import bdq_pkg::*; #(
	parameter int DEPTH      = DEPTH_DEF,
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         we,
	input  wire logic [$clog2(DEPTH)-1:0]     waddr,
	input  wire logic [DATA_WIDTH-1:0]        wdata,
	input  wire logic                         re,
	input  wire logic [$clog2(DEPTH)-1:0]     raddr,
	output logic      [DATA_WIDTH-1:0]        rdata
);

	logic [DATA_WIDTH-1:0] mem [DEPTH];
	logic [DATA_WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

>>> hw/rtl/bdq_ptr.sv
`default_nettype none
module bdq_ptr import bdq_pkg::*; #(
	parameter int DEPTH      = DEPTH_DEF,
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     accept,
	input  wire cmd_beat_t                cmd,
	output logic                          we,
	output logic [$clog2(DEPTH)-1:0]      waddr,
	output logic [DATA_WIDTH-1:0]         wdata,
	output logic                          re,
	output logic [$clog2(DEPTH)-1:0]      raddr,
	output res_t                          res
);

	localparam int AW   = $clog2(DEPTH);
	localparam int CW   = $clog2(DEPTH + 1);
	localparam int SW   = AW + 1;
	localparam int CMPW = (CW > POS_W) ? CW : POS_W;
	localparam logic [SW-1:0] DEPTH_S = SW'(DEPTH);
	localparam logic [CW-1:0] FULL_C  = CW'(DEPTH);

	logic [AW-1:0] head_q, head_d;
	logic [CW-1:0] count_q, count_d;
	logic [SW-1:0] off, sum;
	logic [AW-1:0] idx;
	logic          full, empty, in_range, push, read;
	status_t       status;

	assign full     = (count_q == FULL_C);
	assign empty    = (count_q == '0);
	assign in_range = CMPW'(cmd.position) < CMPW'(count_q);

	always_comb begin
		case (cmd.command)
			CMD_PUSH_FRONT: off = SW'(DEPTH - 1);
			CMD_PUSH_BACK:  off = SW'(count_q);
			CMD_POP_FRONT:  off = SW'(1);
			CMD_READ:       off = SW'(cmd.position);
			default:        off = '0;
		endcase
	end

	// ring wrap: sum stays below twice the depth
	assign sum = {1'b0, head_q} + off;
	assign idx = (sum >= DEPTH_S) ? AW'(sum - DEPTH_S) : AW'(sum);

	always_comb begin
		head_d  = head_q;
		count_d = count_q;
		status  = ST_OK;
		push    = 1'b0;
		read    = 1'b0;
		case (cmd.command)
			CMD_PUSH_FRONT: begin
				if (full) begin
					status = ST_FULL;
				end else begin
					head_d  = idx;
					count_d = count_q + CW'(1);
					push    = 1'b1;
				end
			end
			CMD_PUSH_BACK: begin
				if (full) begin
					status = ST_FULL;
				end else begin
					count_d = count_q + CW'(1);
					push    = 1'b1;
				end
			end
			CMD_POP_FRONT: begin
				if (empty) begin
					status = ST_EMPTY;
				end else begin
					head_d  = idx;
					count_d = count_q - CW'(1);
				end
			end
			CMD_POP_BACK: begin
				if (empty) begin
					status = ST_EMPTY;
				end else begin
					count_d = count_q - CW'(1);
				end
			end
			CMD_READ: begin
				if (in_range) begin
					read = 1'b1;
				end else begin
					status = ST_RANGE;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
		end else if (accept) begin
			head_q  <= head_d;
			count_q <= count_d;
		end
	end

	assign we         = accept && push;
	assign waddr      = idx;
	assign wdata      = DATA_WIDTH'(cmd.value);
	assign re         = accept && read;
	assign raddr      = idx;
	assign res.status = status;
	assign res.rd_ok  = read;
	assign res.length = LEN_W'(count_d);

endmodule
`default_nettype wire

>>> hw/rtl/bounded_deque_with_index_read_unit.sv
// path: a taken command beat is registered in s1, then in the output register,
//   which offers it; s1 waits while rsp_ready holds the output register
// throughput: one command per cycle while s1 can move on; pushes write and
//   in-range reads read the ring at accept, and read data joins the beat as s1 moves on
// reset: head and count clear at once, queue empty; ring contents are not
//   cleared and no clearing pass runs, commands are taken straight after reset
`default_nettype none
module bounded_deque_with_index_read_unit import bdq_pkg::*; #(
	parameter int DEPTH      = DEPTH_DEF,
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      cmd_valid,
	output logic           cmd_ready,
	input  wire cmd_beat_t cmd,
	output logic           rsp_valid,
	input  wire logic      rsp_ready,
	output rsp_beat_t      rsp
);

	localparam int AW = $clog2(DEPTH);

	logic                  accept, adv_s1;
	logic                  we, re;
	logic [AW-1:0]         waddr, raddr;
	logic [DATA_WIDTH-1:0] wdata, rdata;
	res_t                  res;

	logic      valid_s1;
	res_t      res_s1;
	logic      rsp_valid_q;
	rsp_beat_t rsp_q;

	// s1 waits on the memory read; it moves on when the output register frees up
	assign adv_s1    = valid_s1 && (!rsp_valid_q || rsp_ready);
	assign cmd_ready = !valid_s1 || adv_s1;
	assign accept    = cmd_valid && cmd_ready;

	bdq_ptr #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_ptr (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.cmd    (cmd),
		.we     (we),
		.waddr  (waddr),
		.wdata  (wdata),
		.re     (re),
		.raddr  (raddr),
		.res    (res)
	);

	bdq_ram #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_s1 <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (adv_s1) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			rsp_q.status    <= res_s1.status;
			rsp_q.read_word <= res_s1.rd_ok ? WORD_W'(rdata) : '0;
			rsp_q.length    <= res_s1.length;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule
`default_nettype wire

>>> tb/tb.sv
`timescale 1ns / 1ps
module tb;
	import bdq_pkg::*;

	localparam int RANDOM_ITEMS = 1800;
	localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd5;
	localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

	typedef enum int {PH_FILL, PH_DRAIN, PH_MIXED} phase_t;

	typedef struct {
		cmd_beat_t beat;
		bit        typed;
		rsp_beat_t want;
	} plan_row_t;

	logic      clk;
	logic      arst_n;
	logic      cmd_valid;
	logic      cmd_ready;
	cmd_beat_t cmd;
	logic      rsp_valid;
	logic      rsp_ready;
	rsp_beat_t rsp;

	// shadow of the deque
	logic [WORD_W-1:0] ring_words [DEPTH_DEF];
	logic [POS_W-1:0]  front_idx;
	logic [LEN_W-1:0]  fill_count;

	rsp_beat_t rsp_owed_q[$];
	plan_row_t plan_rows[$];
	int        mismatches;

	bounded_deque_with_index_read_unit u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd      (cmd),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("tb: done, errors");
		$finish;
	end

	function automatic rsp_beat_t deque_apply(cmd_beat_t b);
		rsp_beat_t r;
		logic [POS_W-1:0] idx;
		r.status    = ST_OK;
		r.read_word = '0;
		case (b.command)
			CMD_PUSH_FRONT: begin
				if (fill_count == LEN_W'(DEPTH_DEF)) begin
					r.status = ST_FULL;
				end else begin
					front_idx = front_idx - 1'b1;
					ring_words[front_idx] = b.value;
					fill_count++;
				end
			end
			CMD_PUSH_BACK: begin
				if (fill_count == LEN_W'(DEPTH_DEF)) begin
					r.status = ST_FULL;
				end else begin
					idx = front_idx + POS_W'(fill_count);
					ring_words[idx] = b.value;
					fill_count++;
				end
			end
			CMD_POP_FRONT: begin
				if (fill_count == 0) begin
					r.status = ST_EMPTY;
				end else begin
					front_idx = front_idx + 1'b1;
					fill_count--;
				end
			end
			CMD_POP_BACK: begin
				if (fill_count == 0)
					r.status = ST_EMPTY;
				else
					fill_count--;
			end
			CMD_READ: begin
				if (LEN_W'(b.position) >= fill_count) begin
					r.status = ST_RANGE;
				end else begin
					idx = front_idx + b.position;
					r.read_word = ring_words[idx];
				end
			end
			default: ;
		endcase
		r.length = fill_count;
		return r;
	endfunction

	function automatic void add_row(logic [CMD_W-1:0] c, logic [WORD_W-1:0] v,
			logic [POS_W-1:0] p, bit typed, status_t s, logic [WORD_W-1:0] w,
			logic [LEN_W-1:0] len);
		plan_row_t row;
		row.beat.command   = cmd_t'(c);
		row.beat.value     = v;
		row.beat.position  = p;
		row.typed          = typed;
		row.want.status    = s;
		row.want.read_word = w;
		row.want.length    = len;
		plan_rows.push_back(row);
	endfunction

	function automatic cmd_beat_t pick_beat(phase_t ph);
		cmd_beat_t b;
		int        push_w;
		int        pop_w;
		int        roll;
		push_w = (ph == PH_FILL) ? 65 : (ph == PH_DRAIN) ? 10 : 35;
		pop_w  = (ph == PH_FILL) ? 10 : (ph == PH_DRAIN) ? 65 : 35;
		roll   = $urandom_range(0, 99);
		if (roll < push_w)
			b.command = $urandom_range(0, 1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
		else if (roll < push_w + pop_w)
			b.command = $urandom_range(0, 1) ? CMD_POP_BACK : CMD_POP_FRONT;
		else if (roll < 95)
			b.command = CMD_READ;
		else
			b.command = cmd_t'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
		case ($urandom_range(0, 9))
			0: b.value = '0;
			1: b.value = '1;
			default: b.value = $urandom;
		endcase
		// mostly aim reads at live entries, sometimes anywhere
		if (fill_count != 0 && $urandom_range(0, 4) != 0)
			b.position = POS_W'($urandom_range(0, fill_count - 1));
		else
			b.position = POS_W'($urandom_range(0, DEPTH_DEF - 1));
		return b;
	endfunction

	task automatic send_beat(cmd_beat_t b, int gap, bit typed, rsp_beat_t want);
		rsp_beat_t predicted;
		cmd       <= b;
		cmd_valid <= 1'b1;
		do @(posedge clk); while (!cmd_ready);
		predicted = deque_apply(b);
		rsp_owed_q.push_back(typed ? want : predicted);
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	function automatic int sender_gap(bit burst);
		int roll;
		roll = $urandom_range(0, 99);
		if (burst || roll < 60)
			return 0;
		if (roll < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// receiver: runs of ready with stalls in between, now and then a long run
	initial begin
		int run;
		int gap;
		@(posedge clk);
		forever begin
			run = ($urandom_range(0, 99) < 15) ? $urandom_range(150, 400)
				: $urandom_range(1, 12);
			gap = ($urandom_range(0, 99) < 80) ? $urandom_range(1, 3)
				: $urandom_range(8, 30);
			rsp_ready <= 1'b1;
			repeat (run) @(posedge clk);
			rsp_ready <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		rsp_beat_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (rsp_owed_q.size() == 0) begin
				$display("%0t: unexpected beat, got status %0d word %h length %0d",
					$time, rsp.status, rsp.read_word, rsp.length);
				mismatches++;
			end else begin
				want = rsp_owed_q.pop_front();
				if (rsp.status !== want.status) begin
					$display("%0t: status expected %0d got %0d",
						$time, want.status, rsp.status);
					mismatches++;
				end
				if (rsp.read_word !== want.read_word) begin
					$display("%0t: read_word expected %h got %h",
						$time, want.read_word, rsp.read_word);
					mismatches++;
				end
				if (rsp.length !== want.length) begin
					$display("%0t: length expected %0d got %0d",
						$time, want.length, rsp.length);
					mismatches++;
				end
			end
		end
	end

	initial begin
		int        sent;
		int        phase_no;
		int        phase_len;
		bit        burst;
		phase_t    ph;
		rsp_beat_t none;
		arst_n     = 1'b0;
		cmd_valid  = 1'b0;
		cmd        = '0;
		rsp_ready  = 1'b0;
		mismatches = 0;
		front_idx  = '0;
		fill_count = '0;
		none       = '0;

		// empty queue, extremes, spare codes, then a short push/pop walk
		add_row(CMD_POP_FRONT, '0, '0, 1, ST_EMPTY, '0, 7'd0);
		add_row(CMD_POP_BACK, '1, '1, 1, ST_EMPTY, '0, 7'd0);
		add_row(CMD_READ, '0, 6'd0, 1, ST_RANGE, '0, 7'd0);
		add_row(CMD_READ, '1, 6'd63, 1, ST_RANGE, '0, 7'd0);
		add_row(CMD_PUSH_BACK, 32'hFFFF_FFFF, 6'd63, 1, ST_OK, '0, 7'd1);
		add_row(CMD_PUSH_FRONT, 32'h0000_0000, 6'd0, 1, ST_OK, '0, 7'd2);
		add_row(CMD_READ, '0, 6'd0, 1, ST_OK, 32'h0000_0000, 7'd2);
		add_row(CMD_READ, '0, 6'd1, 1, ST_OK, 32'hFFFF_FFFF, 7'd2);
		add_row(CMD_READ, '0, 6'd2, 1, ST_RANGE, '0, 7'd2);
		add_row(CMD_SPARE_LO, 32'hFFFF_FFFF, 6'd63, 1, ST_OK, '0, 7'd2);
		add_row(CMD_SPARE_HI, 32'hFFFF_FFFF, 6'd0, 1, ST_OK, '0, 7'd2);
		add_row(CMD_PUSH_BACK, 32'h8000_0001, 6'd21, 0, ST_OK, '0, '0);
		add_row(CMD_PUSH_FRONT, 32'h7FFF_FFFE, 6'd42, 0, ST_OK, '0, '0);
		add_row(CMD_READ, '0, 6'd3, 0, ST_OK, '0, '0);
		add_row(CMD_READ, '0, 6'd0, 0, ST_OK, '0, '0);
		add_row(CMD_READ, '0, 6'd4, 0, ST_OK, '0, '0);
		add_row(CMD_POP_BACK, '0, '0, 1, ST_OK, '0, 7'd3);
		add_row(CMD_POP_FRONT, '0, '0, 1, ST_OK, '0, 7'd2);
		add_row(CMD_READ, '0, 6'd1, 0, ST_OK, '0, '0);
		add_row(CMD_POP_FRONT, '0, '0, 1, ST_OK, '0, 7'd1);
		add_row(CMD_POP_BACK, '0, '0, 1, ST_OK, '0, 7'd0);
		add_row(CMD_POP_BACK, '0, '0, 1, ST_EMPTY, '0, 7'd0);

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan_rows[i])
			send_beat(plan_rows[i].beat, sender_gap(0), plan_rows[i].typed,
				plan_rows[i].want);

		// phases push the fill level to both ends and wrap the head around
		sent     = 0;
		phase_no = 0;
		while (sent < RANDOM_ITEMS) begin
			ph        = phase_t'($urandom_range(0, 2));
			phase_len = $urandom_range(40, 160);
			burst     = ($urandom_range(0, 3) == 0);
			if (phase_no == 2 || $urandom_range(0, 4) == 0) begin
				cmd_valid <= 1'b0;
				while (rsp_owed_q.size() != 0) @(posedge clk);
			end
			repeat (phase_len) begin
				send_beat(pick_beat(ph), sender_gap(burst), 0, none);
				sent++;
			end
			phase_no++;
		end
		cmd_valid <= 1'b0;

		while (rsp_owed_q.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

endmodule
